// ===== hw/rtl/lidar_scan_condition_smooth_core_assert.svh =====
// Assertion macros for the lidar scan conditioning and smoothing core.
// Included by the top level; no other dependencies.
`ifndef LIDAR_SCAN_CONDITION_SMOOTH_CORE_ASSERT_SVH
`define LIDAR_SCAN_CONDITION_SMOOTH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lscs: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LSCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lscs: next-cycle check failed");

`endif

// ===== hw/rtl/lscs_pkg.sv =====
// Shared types, constants and helper functions of the lidar scan smoothing core.
// No dependencies.
`default_nettype none
package lscs_pkg;

  localparam int MaxWindow  = 31;
  localparam int FillW      = 5;
  localparam int SampleW    = 16;
  localparam int IndexW     = 12;
  localparam int KindW      = 2;
  localparam int WinW       = 5;
  localparam int SumW       = SampleW + FillW;
  localparam int RecipShift = SumW + FillW;
  localparam int RecipW     = RecipShift + 1;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [KindW-1:0] KindFinite = 2'd0;
  localparam logic [KindW-1:0] KindPosInf = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLOOR  = 3'd0,
    CFG_CAP    = 3'd1,
    CFG_WINDOW = 3'd2,
    CFG_FIRST  = 3'd3,
    CFG_LAST   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] floor_mm;
    logic [SampleW-1:0] cap_mm;
    logic [WinW-1:0]    window;
    logic [IndexW-1:0]  first;
    logic [IndexW-1:0]  last;
  } cfg_t;

  // One classified sample handed from the front to the back.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [IndexW-1:0]  index;
    logic               kept;
    logic               scan_end;
    logic [WinW-1:0]    req;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_SUM,
    B_MUL,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic [FillW-1:0] pending;
    logic             load;
  } back_status_t;

  // Force a window width odd: drop one from an even width, zero becomes one.
  function automatic logic [WinW-1:0] odd_window(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    r = w;
    if (w == '0) begin
      r = WinW'(1);
    end else if (!w[0]) begin
      r = w - WinW'(1);
    end
    return r;
  endfunction

  // ceil(2^RecipShift / w) for odd w; floor(sum * recip >> RecipShift) == sum / w
  // holds exactly for every sum below 2^SumW.
  function automatic logic [RecipW-1:0] recip(input logic [WinW-1:0] w);
    logic [RecipW-1:0] r;
    case (w)
      5'd1:    r = 27'd67108864;
      5'd3:    r = 27'd22369622;
      5'd5:    r = 27'd13421773;
      5'd7:    r = 27'd9586981;
      5'd9:    r = 27'd7456541;
      5'd11:   r = 27'd6100806;
      5'd13:   r = 27'd5162221;
      5'd15:   r = 27'd4473925;
      5'd17:   r = 27'd3947581;
      5'd19:   r = 27'd3532046;
      5'd21:   r = 27'd3195661;
      5'd23:   r = 27'd2917777;
      5'd25:   r = 27'd2684355;
      5'd27:   r = 27'd2485514;
      5'd29:   r = 27'd2314099;
      5'd31:   r = 27'd2164803;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lscs_in_if.sv =====
// Raw sample channel: valid/ready handshake with range, kind and scan end.
// Depends on lscs_pkg.
`default_nettype none
interface lscs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lscs_pkg::SampleW-1:0] range_mm;
  logic [lscs_pkg::KindW-1:0]   range_kind;
  logic                        scan_end;

  modport source (output valid, range_mm, range_kind, scan_end, input ready);
  modport sink (input valid, range_mm, range_kind, scan_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lscs_out_if.sv =====
// Smoothed result channel: valid/ready handshake with range, index and last mark.
// Depends on lscs_pkg.
`default_nettype none
interface lscs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lscs_pkg::SampleW-1:0] smoothed_mm;
  logic [lscs_pkg::IndexW-1:0]  sample_index;
  logic                        run_last;

  modport source (output valid, smoothed_mm, sample_index, run_last, input ready);
  modport sink (input valid, smoothed_mm, sample_index, run_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lidar_scan_condition_smooth_core.sv =====
// Lidar scan conditioning and conservative centred moving-mean smoothing.
// Raw samples enter one per handshake with a raw index counted from the start
// of each scan; only indices inside [first_view_index, last_view_index] are
// kept. Positive infinity becomes the cap, not-a-number (and kind 3) becomes 0,
// a range under the floor becomes 0 and anything above the cap is capped. Each
// kept sample leaves as the lower of itself and the floor-divided mean of an odd
// window centred on it (edges clamped, zero stays zero), tagged with its raw
// index; the last result of a scan carries run_last. Configuration is sampled
// at the first raw sample of a scan. A scan with floor not below cap, or with
// no kept sample, gives no result. Timing: the front takes one sample per cycle
// into a four-entry queue while the queue is not full. The back dequeues and
// decides on each queued entry; for each result the mean is summed one window
// tap a cycle from the 31-entry sample store, then come one reciprocal multiply,
// a result load and the next decide. Steady state is one result per kept
// sample, and the result register may wait on ready; a scan end flushes the
// half window still held.
// Depends on lscs_pkg, lscs_in_if, lscs_out_if, lscs_front, lscs_queue,
// lscs_back and the assertion macro header.
`default_nettype none
`include "lidar_scan_condition_smooth_core_assert.svh"
module lidar_scan_condition_smooth_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lscs_in_if.sink                            samples,
  lscs_out_if.source                         results,
  input  wire logic                          cfg_we,
  input  wire logic [lscs_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lscs_pkg::CfgDataW-1:0] cfg_data
);

  lscs_pkg::cfg_t          cfg;
  logic                    q_push;
  lscs_pkg::entry_t        q_entry;
  logic                    q_full;
  logic                    q_pop;
  lscs_pkg::entry_t        q_data;
  logic                    q_empty;
  lscs_pkg::back_status_t  bk_status;

  // Configuration registers: write by index, ignore unknown indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_mm <= '0;
      cfg.cap_mm   <= lscs_pkg::SampleW'(30000);
      cfg.window   <= lscs_pkg::WinW'(5);
      cfg.first    <= '0;
      cfg.last     <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        lscs_pkg::CFG_FLOOR:  cfg.floor_mm <= cfg_data;
        lscs_pkg::CFG_CAP:    cfg.cap_mm   <= cfg_data;
        lscs_pkg::CFG_WINDOW: cfg.window   <= cfg_data[lscs_pkg::WinW-1:0];
        lscs_pkg::CFG_FIRST:  cfg.first    <= cfg_data[lscs_pkg::IndexW-1:0];
        lscs_pkg::CFG_LAST:   cfg.last     <= cfg_data[lscs_pkg::IndexW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: index, gate by field of view, condition, queue kept samples and ends.
  lscs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Decouple sample intake from the multi-cycle smoothing work.
  lscs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back: hold the window, sweep the mean, drive the result register.
  lscs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .results (results),
    .status  (bk_status)
  );

  // Results still owed never exceed the samples stored.
  `LSCS_ASSERT_IMPL(a_pending_in_store, clk, rst, 1'b1, bk_status.pending <= bk_status.fill)
  // The front never pushes into a full queue.
  `LSCS_ASSERT_IMPL(a_push_has_room, clk, rst, q_push, !q_full)
  // A result is loaded only into a free or draining output register.
  `LSCS_ASSERT_IMPL(a_load_when_free, clk, rst, bk_status.load,
                    !results.valid || results.ready)
  // A loaded result is presented on the next cycle.
  `LSCS_ASSERT_NEXT(a_load_shows, clk, rst, bk_status.load, results.valid)

endmodule
`default_nettype wire

// ===== hw/rtl/lscs_front.sv =====
// Front end: counts raw indices, latches configuration per scan, conditions
// the range and queues kept samples and scan ends. Depends on lscs_pkg, lscs_in_if.
`default_nettype none
module lscs_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lscs_pkg::cfg_t   cfg,
  lscs_in_if.sink               samples,
  input  wire logic             q_full,
  output logic                  q_push,
  output lscs_pkg::entry_t      q_entry
);

  logic                          in_scan;
  logic [lscs_pkg::IndexW-1:0]   raw_index;
  lscs_pkg::cfg_t                lat;
  lscs_pkg::cfg_t                eff;
  logic                          accept;
  logic                          kept;
  logic [lscs_pkg::SampleW-1:0]  cond;

  assign samples.ready = !q_full;
  assign accept = samples.valid && samples.ready;
  // first sample of a scan sees the live registers
  assign eff = in_scan ? lat : cfg;

  assign kept = (eff.floor_mm < eff.cap_mm) && (raw_index >= eff.first) &&
                (raw_index <= eff.last);

  always_comb begin
    if (samples.range_kind == lscs_pkg::KindPosInf) begin
      cond = eff.cap_mm;
    end else if (samples.range_kind != lscs_pkg::KindFinite) begin
      cond = '0;
    end else begin
      cond = samples.range_mm;
    end
    if (cond < eff.floor_mm) begin
      cond = '0;
    end else if (cond > eff.cap_mm) begin
      cond = eff.cap_mm;
    end
  end

  assign q_push = accept && (kept || samples.scan_end);

  always_comb begin
    q_entry          = '0;
    q_entry.sample   = cond;
    q_entry.index    = raw_index;
    q_entry.kept     = kept;
    q_entry.scan_end = samples.scan_end;
    q_entry.req      = (eff.window == '0) ? lscs_pkg::WinW'(1) : eff.window;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_scan   <= 1'b0;
      raw_index <= '0;
    end else if (accept) begin
      in_scan <= !samples.scan_end;
      if (samples.scan_end) begin
        raw_index <= '0;
      end else begin
        raw_index <= raw_index + lscs_pkg::IndexW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_scan) begin
      lat <= cfg;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lscs_queue.sv =====
// Short register queue of classified samples between front and back.
// Depends on lscs_pkg.
`default_nettype none
module lscs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lscs_pkg::entry_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output lscs_pkg::entry_t       pop_data,
  output logic                   empty
);

  lscs_pkg::entry_t              slots [lscs_pkg::QueueDepth];
  logic [lscs_pkg::QPtrW-1:0]    wr_ptr;
  logic [lscs_pkg::QPtrW-1:0]    rd_ptr;
  logic [lscs_pkg::QCntW-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (count == lscs_pkg::QCntW'(lscs_pkg::QueueDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + lscs_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + lscs_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + lscs_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - lscs_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lscs_back.sv =====
// Back end: keeps the sample window, sweeps the centred mean one tap a cycle,
// divides by reciprocal multiply and drives the result register. Depends on
// lscs_pkg, lscs_out_if.
`default_nettype none
module lscs_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire lscs_pkg::entry_t  q_data,
  output logic                   q_pop,
  lscs_out_if.source             results,
  output lscs_pkg::back_status_t status
);

  localparam int TapW = lscs_pkg::FillW + 2;

  lscs_pkg::back_state_t          state;
  lscs_pkg::back_state_t          state_next;

  logic [lscs_pkg::SampleW-1:0]   buf_sample [lscs_pkg::MaxWindow];
  logic [lscs_pkg::IndexW-1:0]    buf_index  [lscs_pkg::MaxWindow];
  logic [lscs_pkg::FillW-1:0]     fill;
  logic [lscs_pkg::FillW-1:0]     pending;
  logic                           win_set;
  logic [lscs_pkg::WinW-1:0]      win_w;
  logic                           cur_end;
  logic [lscs_pkg::FillW-1:0]     off;
  logic [lscs_pkg::SumW-1:0]      sum;
  logic [lscs_pkg::SampleW-1:0]   v_sample;
  logic [lscs_pkg::IndexW-1:0]    v_index;
  logic [lscs_pkg::SampleW-1:0]   mean;

  logic [lscs_pkg::FillW-1:0]     half;
  logic [lscs_pkg::FillW-1:0]     hold;
  logic [lscs_pkg::FillW-1:0]     center;
  logic [lscs_pkg::FillW-1:0]     fill_m1;
  logic signed [TapW-1:0]         tap;
  logic [lscs_pkg::FillW-1:0]     pos;
  logic [lscs_pkg::FillW-1:0]     fill_new;
  logic [lscs_pkg::FillW-1:0]     pending_new;
  logic                           set_now;
  logic [lscs_pkg::WinW-1:0]      win_w_new;
  logic                           start_sum;
  logic                           clear_scan;
  logic                           load;
  logic [lscs_pkg::SumW+lscs_pkg::RecipW-1:0] product;

  assign half    = win_w >> 1;
  assign hold    = (half == '0) ? lscs_pkg::FillW'(1) : half;
  assign center  = fill - pending;
  assign fill_m1 = fill - lscs_pkg::FillW'(1);

  // clamp the tap to the stored part of the scan
  always_comb begin
    tap = $signed({2'b00, center}) + $signed({2'b00, off}) - $signed({2'b00, half});
    if (tap < 0) begin
      pos = '0;
    end else if (tap > $signed({2'b00, fill_m1})) begin
      pos = fill_m1;
    end else begin
      pos = tap[lscs_pkg::FillW-1:0];
    end
  end

  // window bookkeeping for the entry being taken
  always_comb begin
    fill_new    = fill;
    pending_new = pending;
    if (q_data.kept) begin
      pending_new = pending + lscs_pkg::FillW'(1);
      if (fill != lscs_pkg::FillW'(lscs_pkg::MaxWindow)) begin
        fill_new = fill + lscs_pkg::FillW'(1);
      end
    end
    set_now = q_data.kept && !win_set && (fill_new >= q_data.req);
    if (set_now) begin
      win_w_new = lscs_pkg::odd_window(q_data.req);
    end else if (q_data.scan_end && !win_set) begin
      win_w_new = lscs_pkg::odd_window(fill_new);
    end else begin
      win_w_new = win_w;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    start_sum  = 1'b0;
    clear_scan = 1'b0;
    case (state)
      lscs_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = lscs_pkg::B_CHECK;
        end
      end
      lscs_pkg::B_CHECK: begin
        if (cur_end) begin
          if (pending != '0) begin
            start_sum  = 1'b1;
            state_next = lscs_pkg::B_SUM;
          end else begin
            clear_scan = 1'b1;
            state_next = lscs_pkg::B_IDLE;
          end
        end else if (win_set && (pending > hold)) begin
          start_sum  = 1'b1;
          state_next = lscs_pkg::B_SUM;
        end else begin
          state_next = lscs_pkg::B_IDLE;
        end
      end
      lscs_pkg::B_SUM: begin
        if (off == win_w - lscs_pkg::WinW'(1)) begin
          state_next = lscs_pkg::B_MUL;
        end
      end
      lscs_pkg::B_MUL: begin
        state_next = lscs_pkg::B_OUT;
      end
      lscs_pkg::B_OUT: begin
        if (!results.valid || results.ready) begin
          load       = 1'b1;
          state_next = lscs_pkg::B_CHECK;
        end
      end
      default: begin
        state_next = lscs_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lscs_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      pending       <= '0;
      win_set       <= 1'b0;
      win_w         <= lscs_pkg::WinW'(1);
      cur_end       <= 1'b0;
      off           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        fill    <= fill_new;
        pending <= pending_new;
        win_set <= win_set || set_now;
        win_w   <= win_w_new;
        cur_end <= q_data.scan_end;
      end
      if (clear_scan) begin
        fill    <= '0;
        win_set <= 1'b0;
        win_w   <= lscs_pkg::WinW'(1);
      end
      if (start_sum) begin
        off <= '0;
      end else if (state == lscs_pkg::B_SUM) begin
        off <= off + lscs_pkg::FillW'(1);
      end
      if (load) begin
        pending       <= pending - lscs_pkg::FillW'(1);
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // shift in a kept sample; drop the oldest once the window store is full
  always_ff @(posedge clk) begin
    if (q_pop && q_data.kept) begin
      if (fill == lscs_pkg::FillW'(lscs_pkg::MaxWindow)) begin
        for (int k = 0; k < lscs_pkg::MaxWindow - 1; k++) begin
          buf_sample[k] <= buf_sample[k+1];
          buf_index[k]  <= buf_index[k+1];
        end
        buf_sample[lscs_pkg::MaxWindow-1] <= q_data.sample;
        buf_index[lscs_pkg::MaxWindow-1]  <= q_data.index;
      end else begin
        buf_sample[fill] <= q_data.sample;
        buf_index[fill]  <= q_data.index;
      end
    end
  end

  assign product = {{lscs_pkg::RecipW{1'b0}}, sum} *
                   {{lscs_pkg::SumW{1'b0}}, lscs_pkg::recip(win_w)};

  always_ff @(posedge clk) begin
    if (start_sum) begin
      sum <= '0;
    end else if (state == lscs_pkg::B_SUM) begin
      sum <= sum + {{lscs_pkg::FillW{1'b0}}, buf_sample[pos]};
      if (off == half) begin
        v_sample <= buf_sample[pos];
        v_index  <= buf_index[pos];
      end
    end
    if (state == lscs_pkg::B_MUL) begin
      mean <= product[lscs_pkg::RecipShift +: lscs_pkg::SampleW];
    end
    if (load) begin
      if (v_sample == '0) begin
        results.smoothed_mm <= '0;
      end else if (v_sample < mean) begin
        results.smoothed_mm <= v_sample;
      end else begin
        results.smoothed_mm <= mean;
      end
      results.sample_index <= v_index;
      results.run_last     <= cur_end && (pending == lscs_pkg::FillW'(1));
    end
  end

  always_comb begin
    status         = '0;
    status.fill    = fill;
    status.pending = pending;
    status.load    = load;
  end

endmodule
`default_nettype wire
